/* sv/surm_pkg.sv */
// Shared types and constants for the serial UART register model.
`timescale 1ns / 1ps

package surm_pkg;

  typedef enum logic [1:0] {
    OP_PERIOD = 2'd0,
    OP_DATA   = 2'd1,
    OP_STATUS = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_LINE_LENGTH     = 2'd0,
    CFG_DIRECT_MODE     = 2'd1,
    CFG_OVERRUN_TIMEOUT = 2'd2,
    CFG_NONE            = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV
  } ctrl_state_t;

  localparam int DivSteps = 19;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic [7:0]  LineLengthRst     = 8'd227;
  localparam logic [15:0] OverrunTimeoutRst = 16'd250;
  localparam logic [7:0]  PrefixByte        = 8'ha8;
  localparam logic [9:0]  NineBitMark       = 10'h200;
  localparam logic [9:0]  EightBitMark      = 10'h100;

  typedef struct packed {
    logic exec;
    logic start_div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic period_change;
    logic div_done;
    logic buf_free;
  } sts_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_taken;
    logic        irq_tbe;
    logic        irq_rbf;
    logic        last;
  } result_t;

endpackage

/* sv/serial_uart_register_model.sv */
// Top level of the serial UART register model.
`timescale 1ns / 1ps

// Usage:
//  in_* carries one register access or line tick per item; out_* returns the
//  result items, one per input item, or two when a nine-bit transmit sends
//  its prefix byte first (out_tlast marks the final one).
//  cfg_* writes line_length (0), direct_mode (1) and overrun_timeout (2);
//  write only while no item is in flight.
//  Results are registered: a result appears in the cycle after its item is accepted. A period
//  write that changes the period instead runs the serial divider and a handoff, so its result
//  comes once the divide is done, and no item is taken meanwhile. Other items run at one per
//  cycle while out_tready is high and no item yields two results.
//  The two-entry result buffer lets a new item in during the cycle its last
//  pending result is taken; while out_tready stays low with results pending,
//  in_tready is held low.
//  Reset (rst_n low, synchronous) clears the control state (not the result-buffer data), the
//  port goes inactive and the config registers return to 227, 0 and 250.

module serial_uart_register_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] write_value, [16] host_rx_valid, [24:17] host_rx_byte,
  // [25] host_tx_ready, [31:26] zero
  input  logic [31:0] in_tdata,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] read_data, [16] tx_valid, [24:17] tx_byte, [25] rx_taken,
  // [26] irq_tbe, [27] irq_rbf, [31:28] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  surm_pkg::cmd_t cmd;
  surm_pkg::sts_t sts;

  surm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  surm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* sv/surm_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module surm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [18:0] num,
  input  logic [7:0]  den,
  output logic        done,
  output logic [18:0] quot
);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [surm_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic [18:0]                  acc_r, acc_nxt;
  logic [7:0]                   rem_r, rem_nxt;
  logic [8:0]                   rem_sh;
  logic [8:0]                   rem_sub;

  always_comb begin
    rem_sh   = {rem_r, acc_r[18]};
    rem_sub  = rem_sh - {1'b0, den};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      acc_nxt  = num;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den}) begin
        rem_nxt = rem_sub[7:0];
        acc_nxt = {acc_r[17:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[7:0];
        acc_nxt = {acc_r[17:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == surm_pkg::DivCntW'(surm_pkg::DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

/* sv/surm_dp.sv */
// Datapath: register set, item execution, period divider and result buffer.
`timescale 1ns / 1ps

module surm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata,
  input  surm_pkg::cmd_t       cmd,
  output surm_pkg::sts_t       sts,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  output logic                 out_tlast
);

  surm_pkg::op_t     op;
  surm_pkg::cfg_idx_t cfg_idx;
  logic [15:0] w;
  logic        rv;
  logic [7:0]  rb;
  logic        tr;

  logic [7:0]  line_length_r;
  logic        direct_mode_r;
  logic [15:0] overrun_timeout_r;

  logic [15:0] period_word_r, period_word_nxt;
  logic        nine_bit_r, nine_bit_nxt;
  logic [15:0] period_lines_r, period_lines_nxt;
  logic [15:0] receive_phase_r, receive_phase_nxt;
  logic [15:0] send_phase_r, send_phase_nxt;
  logic [9:0]  tx_holding_r, tx_holding_nxt;
  logic        tx_pending_r, tx_pending_nxt;
  logic        shift_busy_r, shift_busy_nxt;
  logic [9:0]  rx_word_r, rx_word_nxt;
  logic        rx_full_r, rx_full_nxt;
  logic        overrun_flag_r, overrun_flag_nxt;
  logic [7:0]  prefix_held_r, prefix_held_nxt;
  logic [15:0] overrun_timer_r, overrun_timer_nxt;
  logic [15:0] pend_word_r;

  surm_pkg::result_t res0_r, res0_nxt, res1_r, res1_nxt;
  surm_pkg::result_t new0, new1;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  new_cnt;
  logic        pop;
  logic        push;

  logic [18:0] num_base;
  logic [18:0] num;
  logic [7:0]  den;
  logic        div_done;
  logic [18:0] quot;
  logic [15:0] lines;

  logic [15:0] rd;
  logic [1:0]  ntx;
  logic [7:0]  txb0, txb1;
  logic        taken, itbe, irbf;
  logic        fire, send_fire, load;
  logic [16:0] rp_inc;
  logic [16:0] sp_inc;

  assign op      = surm_pkg::op_t'(in_tuser);
  assign cfg_idx = surm_pkg::cfg_idx_t'(cfg_addr);
  assign w       = in_tdata[15:0];
  assign rv      = in_tdata[16];
  assign rb      = in_tdata[24:17];
  assign tr      = in_tdata[25];

  // Period divider: ((w & 0x7fff) + 1) * 10 / line_length (taken as 1 when zero)
  assign num_base = {4'b0, w[14:0]} + 19'd1;
  assign num      = (num_base << 3) + (num_base << 1);
  assign den      = (line_length_r == 8'd0) ? 8'd1 : line_length_r;

  surm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start_div),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_comb begin
    if (direct_mode_r || quot == 19'd0) begin
      lines = 16'd1;
    end else if (quot[18:16] != 3'd0) begin
      lines = 16'hffff;
    end else begin
      lines = quot[15:0];
    end
  end

  assign pop  = out_tvalid && out_tready;
  assign push = cmd.exec || cmd.commit;

  assign sts.period_change = (op == surm_pkg::OP_PERIOD) && (w != period_word_r);
  assign sts.div_done      = div_done;
  assign sts.buf_free      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);

  always_comb begin
    period_word_nxt   = period_word_r;
    nine_bit_nxt      = nine_bit_r;
    period_lines_nxt  = period_lines_r;
    receive_phase_nxt = receive_phase_r;
    send_phase_nxt    = send_phase_r;
    tx_holding_nxt    = tx_holding_r;
    tx_pending_nxt    = tx_pending_r;
    shift_busy_nxt    = shift_busy_r;
    rx_word_nxt       = rx_word_r;
    rx_full_nxt       = rx_full_r;
    overrun_flag_nxt  = overrun_flag_r;
    prefix_held_nxt   = prefix_held_r;
    overrun_timer_nxt = overrun_timer_r;
    rd        = '0;
    taken     = 1'b0;
    itbe      = 1'b0;
    irbf      = 1'b0;
    fire      = 1'b0;
    send_fire = 1'b0;
    load      = 1'b0;
    rp_inc    = {1'b0, receive_phase_r} + 17'd1;
    sp_inc    = {1'b0, send_phase_r} + 17'd1;

    if (cmd.commit) begin
      period_word_nxt   = pend_word_r;
      nine_bit_nxt      = pend_word_r[15];
      period_lines_nxt  = lines;
      receive_phase_nxt = '0;
      send_phase_nxt    = '0;
    end else if (cmd.exec) begin
      unique case (op)
        surm_pkg::OP_PERIOD: begin
          // unchanged period: nothing to do
        end
        surm_pkg::OP_DATA: begin
          tx_holding_nxt = w[9:0];
          if (w[9:0] != 10'd0) begin
            tx_pending_nxt = 1'b1;
            if (!shift_busy_r) begin
              load = 1'b1;
            end
          end
        end
        surm_pkg::OP_STATUS: begin
          rd = {overrun_flag_r, rx_full_r, !tx_pending_r, !shift_busy_r, 2'b00, rx_word_r};
          overrun_flag_nxt = 1'b0;
          rx_full_nxt      = 1'b0;
        end
        surm_pkg::OP_TICK: begin
          if (overrun_timer_r != 16'd0) begin
            overrun_timer_nxt = overrun_timer_r - 16'd1;
          end
          if (period_lines_r != 16'd0) begin
            if (period_lines_r == 16'd1) begin
              fire = 1'b1;
            end else begin
              receive_phase_nxt = rp_inc[15:0];
              if (rp_inc >= {1'b0, period_lines_r - 16'd1}) begin
                fire              = 1'b1;
                receive_phase_nxt = '0;
              end
            end
            if (fire && rv) begin
              if (rx_full_r) begin
                if (overrun_timer_nxt == 16'd0) begin
                  overrun_flag_nxt = 1'b1;
                  irbf             = 1'b1;
                  taken            = 1'b1;
                end
              end else begin
                taken = 1'b1;
                if (nine_bit_r && prefix_held_r == 8'd0) begin
                  // first byte of a pair; anything but a prefix is dropped
                  prefix_held_nxt = ((rb & 8'hfe) == surm_pkg::PrefixByte) ? rb : 8'd0;
                end else begin
                  if (nine_bit_r) begin
                    rx_word_nxt     = {1'b0, prefix_held_r[0], rb} | surm_pkg::NineBitMark;
                    prefix_held_nxt = 8'd0;
                  end else begin
                    rx_word_nxt = {2'b00, rb} | surm_pkg::EightBitMark;
                  end
                  rx_full_nxt       = 1'b1;
                  overrun_timer_nxt = overrun_timeout_r;
                  irbf              = 1'b1;
                end
              end
            end
            send_phase_nxt = sp_inc[15:0];
            if (sp_inc >= {1'b0, period_lines_r}) begin
              send_phase_nxt = '0;
              send_fire      = 1'b1;
            end
            if (send_fire && (tx_pending_r || shift_busy_r)) begin
              if (shift_busy_r && tr) begin
                shift_busy_nxt = 1'b0;
              end
              if (tx_pending_r && !shift_busy_nxt) begin
                load = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (load) begin
      shift_busy_nxt = 1'b1;
      tx_pending_nxt = 1'b0;
      itbe           = 1'b1;
    end
  end

  // Result items for this step
  always_comb begin
    txb1 = tx_holding_nxt[7:0];
    if (load && nine_bit_r) begin
      ntx  = 2'd2;
      txb0 = surm_pkg::PrefixByte | {7'd0, tx_holding_nxt[8]};
    end else if (load) begin
      ntx  = 2'd1;
      txb0 = tx_holding_nxt[7:0];
    end else begin
      ntx  = 2'd0;
      txb0 = 8'd0;
    end
    new0 = '0;
    new1 = '0;
    if (ntx == 2'd2) begin
      new0.tx_valid  = 1'b1;
      new0.tx_byte   = txb0;
      new1.read_data = rd;
      new1.tx_valid  = 1'b1;
      new1.tx_byte   = txb1;
      new1.rx_taken  = taken;
      new1.irq_tbe   = itbe;
      new1.irq_rbf   = irbf;
      new1.last      = 1'b1;
      new_cnt        = 2'd2;
    end else begin
      new0.read_data = rd;
      new0.tx_valid  = ntx[0];
      new0.tx_byte   = txb0;
      new0.rx_taken  = taken;
      new0.irq_tbe   = itbe;
      new0.irq_rbf   = irbf;
      new0.last      = 1'b1;
      new_cnt        = 2'd1;
    end
  end

  always_comb begin
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      res0_nxt = new0;
      res1_nxt = new1;
      cnt_nxt  = new_cnt;
    end else if (pop) begin
      res0_nxt = res1_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r     <= surm_pkg::LineLengthRst;
      direct_mode_r     <= 1'b0;
      overrun_timeout_r <= surm_pkg::OverrunTimeoutRst;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        surm_pkg::CFG_LINE_LENGTH:     line_length_r     <= cfg_wdata[7:0];
        surm_pkg::CFG_DIRECT_MODE:     direct_mode_r     <= cfg_wdata[0];
        surm_pkg::CFG_OVERRUN_TIMEOUT: overrun_timeout_r <= cfg_wdata;
        surm_pkg::CFG_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_word_r   <= '0;
      nine_bit_r      <= 1'b0;
      period_lines_r  <= '0;
      receive_phase_r <= '0;
      send_phase_r    <= '0;
      tx_holding_r    <= '0;
      tx_pending_r    <= 1'b0;
      shift_busy_r    <= 1'b0;
      rx_word_r       <= '0;
      rx_full_r       <= 1'b0;
      overrun_flag_r  <= 1'b0;
      prefix_held_r   <= '0;
      overrun_timer_r <= '0;
      cnt_r           <= '0;
    end else begin
      period_word_r   <= period_word_nxt;
      nine_bit_r      <= nine_bit_nxt;
      period_lines_r  <= period_lines_nxt;
      receive_phase_r <= receive_phase_nxt;
      send_phase_r    <= send_phase_nxt;
      tx_holding_r    <= tx_holding_nxt;
      tx_pending_r    <= tx_pending_nxt;
      shift_busy_r    <= shift_busy_nxt;
      rx_word_r       <= rx_word_nxt;
      rx_full_r       <= rx_full_nxt;
      overrun_flag_r  <= overrun_flag_nxt;
      prefix_held_r   <= prefix_held_nxt;
      overrun_timer_r <= overrun_timer_nxt;
      cnt_r           <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
    if (cmd.start_div) begin
      pend_word_r <= w;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tlast  = res0_r.last;
  assign out_tdata  = {4'b0, res0_r.irq_rbf, res0_r.irq_tbe, res0_r.rx_taken,
                       res0_r.tx_byte, res0_r.tx_valid, res0_r.read_data};

endmodule

/* sv/surm_ctrl.sv */
// Controller: input handshake and sequencing of period divides.
`timescale 1ns / 1ps

module surm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  surm_pkg::sts_t sts,
  output surm_pkg::cmd_t cmd
);

  surm_pkg::ctrl_state_t state_r, state_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= surm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    accept    = 1'b0;
    cmd       = '0;
    unique case (state_r)
      surm_pkg::ST_IDLE: begin
        in_tready = sts.buf_free;
        accept    = in_tvalid && sts.buf_free;
        if (accept && sts.period_change) begin
          cmd.start_div = 1'b1;
          state_nxt     = surm_pkg::ST_DIV;
        end else if (accept) begin
          cmd.exec = 1'b1;
        end
      end
      surm_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = surm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = surm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
